// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit: operation and
// status codes, request and response words, controller commands and states.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    func_e              func;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_req_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    status_e            status;
  } rau_rsp_t;

  // Commands from the controller to the datapath
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SET_ERR,
    CMD_GCD_OPS,
    CMD_DIV_QA,
    CMD_DIV_QB,
    CMD_MUL_DEN,
    CMD_MUL_NUM,
    CMD_MUL_T2,
    CMD_COMBINE,
    CMD_SET_ZERO,
    CMD_GCD_RES,
    CMD_DIV_NUM,
    CMD_DIV_DEN,
    CMD_FINAL,
    CMD_PUBLISH
  } cmd_e;

  // Status from the datapath to the controller
  typedef struct packed {
    logic zero_den;
    logic add_sub;
    logic num_zero;
    logic gcd_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_GCD1,
    S_QA,
    S_QA_W,
    S_QB,
    S_QB_W,
    S_MUL_DEN,
    S_MUL_NUM,
    S_MUL_T2,
    S_COMB,
    S_ZCHK,
    S_GCD2,
    S_DN,
    S_DN_W,
    S_DD,
    S_DD_W,
    S_FIN,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/rau_if.sv -----
// ----------------------------------------------------------------------------
// rau_if
// Valid/ready channels of the rational arithmetic unit: request channel and
// response channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_req_if
  import rau_pkg::*;
;
  logic     valid;
  logic     ready;
  rau_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rau_rsp_if
  import rau_pkg::*;
;
  logic     valid;
  logic     ready;
  rau_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/rau_gcd.sv -----
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd unit: one subtract-or-shift step per cycle on two nonzero
// values, common powers of two counted and restored at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_gcd #(
  parameter int W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [2*W:0]     a_i,
  input  wire logic [2*W:0]     b_i,
  output logic                  done_o,
  output logic [2*W:0]          g_o
);

  localparam int M  = 2 * W + 1;
  localparam int KW = $clog2(M + 1);

  logic          busy_q, busy_d;
  logic [M-1:0]  x_q, x_d, y_q, y_d;
  logic [KW-1:0] k_q, k_d;

  assign done_o = busy_q && (x_q == y_q);
  assign g_o    = x_q << k_q;

  // Step: strip common twos, strip lone twos, subtract odd pair
  always_comb begin
    busy_d = busy_q;
    x_d    = x_q;
    y_d    = y_q;
    k_d    = k_q;
    if (start_i) begin
      busy_d = 1'b1;
      x_d    = a_i;
      y_d    = b_i;
      k_d    = '0;
    end else if (busy_q) begin
      if (x_q == y_q) begin
        busy_d = 1'b0;
      end else if (!x_q[0] && !y_q[0]) begin
        x_d = x_q >> 1;
        y_d = y_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!x_q[0]) begin
        x_d = x_q >> 1;
      end else if (!y_q[0]) begin
        y_d = y_q >> 1;
      end else if (x_q > y_q) begin
        x_d = (x_q - y_q) >> 1;
      end else begin
        y_d = (y_q - x_q) >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    k_q <= k_d;
  end

endmodule

`default_nettype wire

// ----- rtl/rau_div.sv -----
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider: one quotient bit per cycle, used for the exact
// divisions by the gcd.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div #(
  parameter int W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [2*W:0] dividend_i,
  input  wire logic [2*W:0] divisor_i,
  output logic              done_o,
  output logic [2*W:0]      quot_o
);

  localparam int M  = 2 * W + 1;
  localparam int KW = $clog2(M + 1);

  logic          busy_q, busy_d;
  logic [KW-1:0] cnt_q, cnt_d;
  logic [M-1:0]  q_q, q_d, r_q, r_d, d_q, d_d;
  logic [M:0]    rs, diff;
  logic          ge;

  assign done_o = busy_q && (cnt_q == KW'(M));
  assign quot_o = q_q;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    rs     = {r_q, q_q[M-1]};
    diff   = rs - {1'b0, d_q};
    ge     = (rs >= {1'b0, d_q});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    q_d    = q_q;
    r_d    = r_q;
    d_d    = d_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      q_d    = dividend_i;
      r_d    = '0;
      d_d    = divisor_i;
    end else if (busy_q) begin
      if (cnt_q == KW'(M)) begin
        busy_d = 1'b0;
      end else begin
        r_d   = ge ? diff[M-1:0] : rs[M-1:0];
        q_d   = {q_q[M-2:0], ge};
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    q_q   <= q_d;
    r_q   <= r_d;
    d_q   <= d_d;
  end

endmodule

`default_nettype wire

// ----- rtl/rau_dp.sv -----
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand split, shared multiplier, sign combine, gcd and divider
// units, overflow check and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_dp
  import rau_pkg::*;
#(
  parameter int W = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_e       cmd_i,
  input  wire rau_req_t   req_i,
  output dp_status_t      st_o,
  output rau_rsp_t        rsp_o,
  output logic            rsp_valid_o,
  input  wire logic       rsp_ready_i
);

  localparam int M = 2 * W + 1;
  localparam logic [M-1:0] HALF = M'(1) << (W - 1);

  func_e        func_q;
  logic [W-1:0] an_q, ad_q, bn_q, bd_q, qa_q, qb_q;
  logic         as_q, bs_q, neg_q;
  logic [M-1:0] num_q, den_q, t2_q, g_q;
  cmd_e         dst_q;
  rau_rsp_t     res_q, out_q;
  logic         out_valid_q;

  logic         add_sub;
  logic [W:0]   an_s, ad_s, bn_s, bd_s;
  logic [W-1:0] mul_a, mul_b;
  logic [2*W-1:0] prod;
  logic         gcd_start, gcd_done, div_start, div_done;
  logic [M-1:0] gcd_a, gcd_b, gcd_g, div_n, div_q;
  logic         ovf;
  logic signed [W-1:0] num_s;

  function automatic logic [W:0] split(input logic [31:0] raw);
    logic [W-1:0] v;
    logic [W-1:0] mag;
    v   = raw[W-1:0];
    mag = v[W-1] ? (~v + 1'b1) : v;
    return {v[W-1], mag};
  endfunction

  assign an_s = split(req_i.a_num);
  assign ad_s = split(req_i.a_den);
  assign bn_s = split(req_i.b_num);
  assign bd_s = split(req_i.b_den);

  assign add_sub = (func_q == FUNC_ADD) || (func_q == FUNC_SUB);

  // Status toward the controller
  assign st_o.zero_den = (ad_q == '0) || (bd_q == '0) ||
                         ((func_q == FUNC_DIV) && (bn_q == '0));
  assign st_o.add_sub  = add_sub;
  assign st_o.num_zero = (num_q == '0);
  assign st_o.gcd_done = gcd_done;
  assign st_o.div_done = div_done;
  assign st_o.out_free = !out_valid_q || rsp_ready_i;

  // Multiplier operand select
  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    case (cmd_i)
      CMD_MUL_DEN: begin
        mul_a = add_sub ? qa_q : ad_q;
        mul_b = (func_q == FUNC_DIV) ? bn_q : bd_q;
      end
      CMD_MUL_NUM: begin
        mul_a = an_q;
        mul_b = add_sub ? qb_q : ((func_q == FUNC_MUL) ? bn_q : bd_q);
      end
      CMD_MUL_T2: begin
        mul_a = bn_q;
        mul_b = qa_q;
      end
      default: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Gcd unit: the denominators first for add and subtract, then the exact result
  assign gcd_start = (cmd_i == CMD_GCD_OPS) || (cmd_i == CMD_GCD_RES);
  assign gcd_a     = (cmd_i == CMD_GCD_RES) ? num_q : M'(ad_q);
  assign gcd_b     = (cmd_i == CMD_GCD_RES) ? den_q : M'(bd_q);

  rau_gcd #(.W(W)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (gcd_a),
    .b_i     (gcd_b),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  // Divider: every division is by the stored gcd
  assign div_start = (cmd_i == CMD_DIV_QA) || (cmd_i == CMD_DIV_QB) ||
                     (cmd_i == CMD_DIV_NUM) || (cmd_i == CMD_DIV_DEN);

  always_comb begin
    case (cmd_i)
      CMD_DIV_QA:  div_n = M'(ad_q);
      CMD_DIV_QB:  div_n = M'(bd_q);
      CMD_DIV_NUM: div_n = num_q;
      default:     div_n = den_q;
    endcase
  end

  rau_div #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (g_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // Overflow check and signed result numerator
  assign ovf   = (den_q > HALF - 1'b1) ||
                 (neg_q ? (num_q > HALF) : (num_q > HALF - 1'b1));
  assign num_s = neg_q ? -num_q[W-1:0] : num_q[W-1:0];

  // Working registers
  always_ff @(posedge clk_i) begin
    if (gcd_done) begin
      g_q <= gcd_g;
    end
    if (div_done) begin
      case (dst_q)
        CMD_DIV_QA:  qa_q  <= div_q[W-1:0];
        CMD_DIV_QB:  qb_q  <= div_q[W-1:0];
        CMD_DIV_NUM: num_q <= div_q;
        default:     den_q <= div_q;
      endcase
    end
    if (div_start) begin
      dst_q <= cmd_i;
    end
    case (cmd_i)
      CMD_LOAD: begin
        func_q <= req_i.func;
        an_q   <= an_s[W-1:0];
        ad_q   <= ad_s[W-1:0];
        bn_q   <= bn_s[W-1:0];
        bd_q   <= bd_s[W-1:0];
        as_q   <= an_s[W] ^ ad_s[W];
        bs_q   <= bn_s[W] ^ bd_s[W] ^ (req_i.func == FUNC_SUB);
      end
      CMD_MUL_DEN: den_q <= M'(prod);
      CMD_MUL_NUM: num_q <= M'(prod);
      CMD_MUL_T2:  t2_q  <= M'(prod);
      CMD_COMBINE: begin
        if (!add_sub) begin
          neg_q <= as_q ^ bs_q;
        end else if (as_q == bs_q) begin
          num_q <= num_q + t2_q;
          neg_q <= as_q;
        end else if (num_q >= t2_q) begin
          num_q <= num_q - t2_q;
          neg_q <= as_q;
        end else begin
          num_q <= t2_q - num_q;
          neg_q <= bs_q;
        end
      end
      CMD_SET_ERR: begin
        res_q.res_num <= '0;
        res_q.res_den <= '0;
        res_q.status  <= ST_ZERO_DEN;
      end
      CMD_SET_ZERO: begin
        res_q.res_num <= '0;
        res_q.res_den <= 31'd1;
        res_q.status  <= ST_OK;
      end
      CMD_FINAL: begin
        res_q.res_num <= ovf ? '0 : 32'(num_s);
        res_q.res_den <= ovf ? '0 : 31'(den_q[W-1:0]);
        res_q.status  <= ovf ? ST_OVERFLOW : ST_OK;
      end
      CMD_PUBLISH: out_q <= res_q;
      default: ;
    endcase
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == CMD_PUBLISH) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_o       = out_q;
  assign rsp_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_ok_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_OK) |-> (out_q.res_den != '0))
    else $error("ok word with zero denominator");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |->
      (out_q.res_num == '0 && out_q.res_den == '0))
    else $error("error word carries nonzero fields");

  a_gcd_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_done |-> (gcd_g != '0))
    else $error("gcd of zero");
`endif

endmodule

`default_nettype wire

// ----- rtl/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl
// Controller: sequences load, gcd, divisions, multiplies, combine, reduce
// and publish for one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl
  import rau_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_valid_i,
  output logic            req_ready_o,
  input  wire dp_status_t st_i,
  output cmd_e            cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st_i.zero_den) begin
          cmd_o   = CMD_SET_ERR;
          state_d = S_OUT;
        end else if (st_i.add_sub) begin
          cmd_o   = CMD_GCD_OPS;
          state_d = S_GCD1;
        end else begin
          state_d = S_MUL_DEN;
        end
      end
      S_GCD1: if (st_i.gcd_done) state_d = S_QA;
      S_QA: begin
        cmd_o   = CMD_DIV_QA;
        state_d = S_QA_W;
      end
      S_QA_W: if (st_i.div_done) state_d = S_QB;
      S_QB: begin
        cmd_o   = CMD_DIV_QB;
        state_d = S_QB_W;
      end
      S_QB_W: if (st_i.div_done) state_d = S_MUL_DEN;
      S_MUL_DEN: begin
        cmd_o   = CMD_MUL_DEN;
        state_d = S_MUL_NUM;
      end
      S_MUL_NUM: begin
        cmd_o   = CMD_MUL_NUM;
        state_d = st_i.add_sub ? S_MUL_T2 : S_COMB;
      end
      S_MUL_T2: begin
        cmd_o   = CMD_MUL_T2;
        state_d = S_COMB;
      end
      S_COMB: begin
        cmd_o   = CMD_COMBINE;
        state_d = S_ZCHK;
      end
      S_ZCHK: begin
        if (st_i.num_zero) begin
          cmd_o   = CMD_SET_ZERO;
          state_d = S_OUT;
        end else begin
          cmd_o   = CMD_GCD_RES;
          state_d = S_GCD2;
        end
      end
      S_GCD2: if (st_i.gcd_done) state_d = S_DN;
      S_DN: begin
        cmd_o   = CMD_DIV_NUM;
        state_d = S_DN_W;
      end
      S_DN_W: if (st_i.div_done) state_d = S_DD;
      S_DD: begin
        cmd_o   = CMD_DIV_DEN;
        state_d = S_DD_W;
      end
      S_DD_W: if (st_i.div_done) state_d = S_FIN;
      S_FIN: begin
        cmd_o   = CMD_FINAL;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (st_i.out_free) begin
          cmd_o   = CMD_PUBLISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_load_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_ready_o && req_valid_i) |=> (state_q == S_CHECK))
    else $error("accepted word not loaded");

  a_publish_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == CMD_PUBLISH) |-> st_i.out_free)
    else $error("publish over a pending word");

  a_ready_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> !req_ready_o)
    else $error("ready before result published");
`endif

endmodule

`default_nettype wire

// ----- rtl/rational_arithmetic_unit.sv -----
// Run time is set by the one-step-per-cycle binary gcd and the bit-serial divisions (four
// divisions for add and subtract, two otherwise); errors skip the gcd and the divisions,
// and zero results skip the final reduction.
// Throughput: one word at a time; the next word is taken once the previous result sits in
// the output register. Reset clears the controller and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Signed fraction add, subtract, multiply and divide with gcd reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rau_req_if.sink    req_i,
  rau_rsp_if.source  rsp_o
);

  cmd_e       cmd;
  dp_status_t st;
  logic       ready;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  rau_dp #(.W(OPERAND_WIDTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i.data),
    .st_o        (st),
    .rsp_o       (rsp_o.data),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready)
  );

  assign req_i.ready = ready;

endmodule

`default_nettype wire

// ----- verif/rau_tb_if.sv -----
// ----------------------------------------------------------------------------
// rau_tb_if
// Testbench-side notes: the block's channel interfaces come from the RTL;
// this file holds the shared constants of the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package rau_tb_pkg;
  localparam int unsigned OPW        = 32;
  localparam int unsigned WATCH_LIM  = 20000;
  localparam int unsigned DRAIN_WAIT = 500;
endpackage

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction words through the request channel with random gaps, holds
// its own model of the reduced fraction arithmetic and compares each response
// word field by field with the oldest expected fraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import rau_pkg::*;
  import rau_tb_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   err_cnt;
  int   idle_cycles;
  bit   rsp_hold;
  int   rsp_hold_cycles;

  rau_req_if req_if ();
  rau_rsp_if rsp_if ();

  rau_rsp_t exp_fracs[$];

  rational_arithmetic_unit #(.OPERAND_WIDTH(OPW)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Split a field into sign and magnitude
  function automatic logic [63:0] mag_of(logic [31:0] raw, output bit neg);
    logic [31:0] m;
    neg = raw[31];
    m   = neg ? -raw : raw;
    return 64'(m);
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Compute the reduced fraction for one request word
  function automatic rau_rsp_t reduce_frac(rau_req_t q);
    rau_rsp_t    r;
    bit          an_n, ad_n, bn_n, bd_n, as, bs, neg;
    logic [63:0] an, ad, bn, bd, num, den, g, t1, t2, half;
    an = mag_of(q.a_num, an_n);
    ad = mag_of(q.a_den, ad_n);
    bn = mag_of(q.b_num, bn_n);
    bd = mag_of(q.b_den, bd_n);
    as = an_n != ad_n;
    bs = bn_n != bd_n;
    r = '{res_num: '0, res_den: '0, status: ST_ZERO_DEN};
    if (ad == 0 || bd == 0 || (q.func == FUNC_DIV && bn == 0)) return r;
    if (q.func == FUNC_ADD || q.func == FUNC_SUB) begin
      if (q.func == FUNC_SUB) bs = !bs;
      g   = gcd64(ad, bd);
      den = (ad / g) * bd;
      t1  = an * (bd / g);
      t2  = bn * (ad / g);
      if (as == bs) begin
        num = t1 + t2;
        neg = as;
      end else if (t1 >= t2) begin
        num = t1 - t2;
        neg = as;
      end else begin
        num = t2 - t1;
        neg = bs;
      end
    end else if (q.func == FUNC_MUL) begin
      num = an * bn;
      den = ad * bd;
      neg = as != bs;
    end else begin
      num = an * bd;
      den = ad * bn;
      neg = as != bs;
    end
    if (num == 0) return '{res_num: '0, res_den: 31'd1, status: ST_OK};
    g    = gcd64(num, den);
    num  = num / g;
    den  = den / g;
    half = 64'd1 << 31;
    if (den > half - 1 || (neg ? num > half : num > half - 1))
      return '{res_num: '0, res_den: '0, status: ST_OVERFLOW};
    r.res_num = neg ? 32'(-num) : 32'(num);
    r.res_den = den[30:0];
    r.status  = ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // Send one word after a random gap; valid stays up when the next word follows at once
  task automatic send_frac(func_e f, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.data  <= '{func: f, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    req_if.valid <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    exp_fracs = {exp_fracs,
                 reduce_frac('{func: f, a_num: an, a_den: ad, b_num: bn, b_den: bd})};
  endtask

  // Response ready with random stalls, plus a forced long hold
  always @(posedge clk_i) begin
    if (rsp_hold) begin
      rsp_if.ready <= 1'b0;
      rsp_hold_cycles <= rsp_hold_cycles + 1;
    end else if ($urandom_range(0, 19) == 0) begin
      rsp_if.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      rsp_if.ready <= ~rsp_if.ready;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Compare each response word with the oldest expected fraction
  always @(posedge clk_i) begin
    rau_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (exp_fracs.size() == 0) begin
        report_mismatch("unexpected word", rsp_if.data.res_num, 0);
      end else begin
        want = exp_fracs.pop_front();
        if (rsp_if.data.res_num !== want.res_num)
          report_mismatch("res_num", rsp_if.data.res_num, want.res_num);
        if (rsp_if.data.res_den !== want.res_den)
          report_mismatch("res_den", 32'(rsp_if.data.res_den), 32'(want.res_den));
        if (rsp_if.data.status !== want.status)
          report_mismatch("status", 32'(rsp_if.data.status), 32'(want.status));
      end
    end
  end

  // Watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCH_LIM) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Drop valid and hold until every expected word has come back
  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (exp_fracs.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 16);
      1:       return -$urandom_range(1, 16);
      2:       return $urandom_range(0, 1000) - 500;
      3:       return 32'h8000_0000 + $urandom_range(0, 3);
      4:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_den();
    logic [31:0] v;
    v = rand_val();
    if (v == 0 && $urandom_range(0, 15) != 0) v = 1;
    return v;
  endfunction

  // Extremes, each operation and each special case
  task automatic test_directed();
    send_frac(FUNC_ADD, 1, 2, 1, 3);
    send_frac(FUNC_SUB, 1, 2, 1, 2);
    send_frac(FUNC_MUL, -2, 4, 3, -9);
    send_frac(FUNC_DIV, 3, 4, -3, 8);
    send_frac(FUNC_ADD, 5, 0, 1, 1);
    send_frac(FUNC_MUL, 5, 1, 1, 0);
    send_frac(FUNC_DIV, 5, 7, 0, 3);
    send_frac(FUNC_ADD, 0, 5, 0, -3);
    send_frac(FUNC_ADD, 32'h7FFF_FFFF, 1, 1, 1);
    send_frac(FUNC_SUB, 32'h8000_0000, 1, 1, 1);
    send_frac(FUNC_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    send_frac(FUNC_DIV, 1, 32'h8000_0000, -1, 1);
    send_frac(FUNC_DIV, 1, 32'h8000_0000, 1, 1);
    send_frac(FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 1, 1);
    send_frac(FUNC_ADD, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE);
    send_frac(FUNC_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_frac(FUNC_SUB, 6, 4, 6, 4);
    wait_drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_frac(func_e'($urandom_range(0, 3)), rand_val(), rand_den(),
                         rand_val(), rand_den());
  endtask

  // Hold the response side so the block fills and stalls its input
  task automatic test_backpressure();
    rsp_hold_cycles = 0;
    rsp_hold = 1'b1;
    fork
      test_random(6);
      begin
        while (rsp_hold_cycles < 2000) @(posedge clk_i);
        rsp_hold = 1'b0;
      end
    join
    wait_drain();
  endtask

  initial begin
    err_cnt      = 0;
    idle_cycles  = 0;
    rsp_hold     = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(980);
    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0 && exp_fracs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_gcd.sv
rtl/rau_div.sv
rtl/rau_dp.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit.sv
verif/rau_tb_if.sv
verif/testbench.sv
